// File: rtl/core/jlgs_pkg.sv
`default_nettype none
package jlgs_pkg;

   // Field widths fixed by the interface.
   localparam int VALUE_W    = 24;
   localparam int ITER_W     = 20;
   localparam int SIZE_W     = 7;
   localparam int COORD_W    = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // Default grid dimension and fixed-point format.
   localparam int GRID_MAX_DEFAULT = 64;
   localparam int FRACTION_BITS    = 16;

   // Width of the boundary interpolation arithmetic.
   localparam int DIV_W = 32;

   localparam logic [DIV_W-1:0] TEN_FX    = DIV_W'(10) << FRACTION_BITS;
   localparam logic [DIV_W-1:0] TWENTY_FX = DIV_W'(20) << FRACTION_BITS;
   localparam logic [DIV_W-1:0] VALUE_MAX = DIV_W'((64'd1 << VALUE_W) - 64'd1);

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER  = 2'd2;

   // Command codes.
   localparam logic MODE_SOLVE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] column;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] cell_value;
      logic [ITER_W-1:0]  iterations_used;
      logic [VALUE_W-1:0] final_error;
      logic               status;
   } rsp_type;

   // Saturate a boundary value to the cell width.
   function automatic logic [VALUE_W-1:0] sat_value(input logic [DIV_W-1:0] v);
      logic [VALUE_W-1:0] r;
      r = (v > VALUE_MAX) ? VALUE_MAX[VALUE_W-1:0] : v[VALUE_W-1:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/jlgs_ram.sv
`default_nettype none
module jlgs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_address,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_address,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data <= mem_ff[read_address];
   end

endmodule
`default_nettype wire

// File: rtl/core/jacobi_laplace_grid_solver_core.sv
`default_nettype none
// Jacobi solver for the 2D Laplace equation on a square grid, five-point stencil.
// A request on the req_ channel is either a solve (mode 0) or a read of one cell
// (mode 1); every request yields exactly one response on the rsp_ channel.
// The block takes one request at a time: req_ready is high only while it is idle.
// A solve of an n by n grid in a memory of G by G cells (G = GRID_MAX) runs a
// bit-serial divide for the boundary step, a zeroing pass over every cell of both
// memories, a boundary pass, then the sweeps; each interior cell takes five reads
// per sweep through the single read port of the source grid memory. A read passes
// through the RADDR, RDATA and FINISH states; a bad index goes straight to FINISH.
// Configuration is written through csr_ while idle: the user must keep to this,
// the block does not enforce it. A write takes effect at once.
// Responses sit in an output register; a stalled receiver holds the response,
// and the block can still accept the next request, which waits to be answered.
// Synchronous reset clears the control state, the sweep statistics and the
// registers to their defaults; grid memories are not cleared.
module jacobi_laplace_grid_solver_core #(
   parameter int GRID_MAX = jlgs_pkg::GRID_MAX_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire jlgs_pkg::req_type                  req_payload,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output jlgs_pkg::rsp_type                       rsp_payload,
   input  wire logic                               csr_write_enable,
   input  wire logic [jlgs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [jlgs_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import jlgs_pkg::*;

   localparam int NW    = $clog2(GRID_MAX + 1);
   localparam int DEPTH = GRID_MAX * GRID_MAX;
   localparam int AW    = $clog2(DEPTH);
   localparam int SUM_W = VALUE_W + 2;

   localparam logic [NW-1:0] CELL_LAST = NW'(GRID_MAX - 1);

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
   localparam logic [ST_W-1:0] ST_DIV    = 3'd1;
   localparam logic [ST_W-1:0] ST_ZERO   = 3'd2;
   localparam logic [ST_W-1:0] ST_EDGE   = 3'd3;
   localparam logic [ST_W-1:0] ST_SWEEP  = 3'd4;
   localparam logic [ST_W-1:0] ST_RADDR  = 3'd5;
   localparam logic [ST_W-1:0] ST_RDATA  = 3'd6;
   localparam logic [ST_W-1:0] ST_FINISH = 3'd7;

   localparam logic [2:0] PH_LAST = 3'd5;

   logic [ST_W-1:0]    state_ff, state_in;
   logic               sel_ff, sel_in;
   logic [ITER_W-1:0]  sweep_count_ff, sweep_count_in;
   logic [VALUE_W-1:0] sweep_error_ff, sweep_error_in;
   logic [SIZE_W-1:0]  grid_size_ff;
   logic [VALUE_W-1:0] tolerance_ff;
   logic [ITER_W-1:0]  max_iter_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [VALUE_W-1:0] pend_cell_ff, pend_cell_in;
   logic               pend_status_ff, pend_status_in;
   logic [NW-1:0]      i_ff, i_in, j_ff, j_in;
   logic [2:0]         phase_ff, phase_in;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [NW-1:0]      rem_ff, rem_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [DIV_W-1:0]   d_ff, d_in;
   logic [NW-1:0]      r_ff, r_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [VALUE_W-1:0] err_ff, err_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;

   logic [NW-1:0]      n_use, last;
   logic [ITER_W-1:0]  limit;
   logic [NW:0]        trial, rsum;
   logic               req_fire, out_free, row_bad;
   logic [NW-1:0]      rd_row, rd_col, wr_row, wr_col;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic               we_a, we_b;
   logic [VALUE_W-1:0] wr_data, rd_a, rd_b, src_data, new_val, diff, err_upd;
   logic [ITER_W-1:0]  iter_next;

   // Grid size in use, clamped to the supported range.
   always_comb begin
      if (grid_size_ff < SIZE_W'(3)) begin
         n_use = NW'(3);
      end else if (32'(grid_size_ff) > 32'(GRID_MAX)) begin
         n_use = NW'(GRID_MAX);
      end else begin
         n_use = NW'(grid_size_ff);
      end
      last  = n_use - NW'(1);
      limit = (max_iter_ff == '0) ? ITER_W'(1) : max_iter_ff;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign row_bad   = (32'(req_payload.row) >= 32'(n_use))
                   || (32'(req_payload.column) >= 32'(n_use));

   assign rd_addr  = AW'(rd_row) * AW'(GRID_MAX) + AW'(rd_col);
   assign wr_addr  = AW'(wr_row) * AW'(GRID_MAX) + AW'(wr_col);
   assign src_data = sel_ff ? rd_b : rd_a;

   // Divide step, boundary accumulation and stencil arithmetic.
   assign trial     = {rem_ff, quo_ff[DIV_W-1]};
   assign rsum      = {1'b0, r_ff} + {1'b0, rem_ff};
   assign new_val   = sum_ff[SUM_W-1:2];
   assign diff      = new_val - src_data;
   assign err_upd   = ((new_val > src_data) && (diff > err_ff)) ? diff : err_ff;
   assign iter_next = iter_ff + ITER_W'(1);

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      sel_in         = sel_ff;
      sweep_count_in = sweep_count_ff;
      sweep_error_in = sweep_error_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;
      pend_cell_in   = pend_cell_ff;
      pend_status_in = pend_status_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      phase_in       = phase_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      cnt_in         = cnt_ff;
      d_in           = d_ff;
      r_in           = r_ff;
      sum_in         = sum_ff;
      err_in         = err_ff;
      iter_in        = iter_ff;
      rd_row         = i_ff;
      rd_col         = j_ff;
      wr_row         = i_ff;
      wr_col         = j_ff;
      we_a           = 1'b0;
      we_b           = 1'b0;
      wr_data        = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_payload.mode == MODE_SOLVE) begin
                  quo_in   = TEN_FX;
                  rem_in   = '0;
                  cnt_in   = '0;
                  iter_in  = '0;
                  state_in = ST_DIV;
               end else if (row_bad) begin
                  pend_cell_in   = '0;
                  pend_status_in = 1'b1;
                  state_in       = ST_FINISH;
               end else begin
                  i_in     = NW'(req_payload.row);
                  j_in     = NW'(req_payload.column);
                  state_in = ST_RADDR;
               end
            end
         end
         ST_DIV: begin
            // One quotient bit a cycle of the boundary step.
            if (trial >= {1'b0, last}) begin
               rem_in = NW'(trial - {1'b0, last});
               quo_in = {quo_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in = trial[NW-1:0];
               quo_in = {quo_ff[DIV_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_W - 1)) begin
               i_in     = '0;
               j_in     = '0;
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            // Clear every cell of both buffers, so cells outside the grid in use
            // also read as zero afterwards.
            we_a = 1'b1;
            we_b = 1'b1;
            if (j_ff == CELL_LAST) begin
               j_in = '0;
               if (i_ff == CELL_LAST) begin
                  i_in     = '0;
                  phase_in = '0;
                  d_in     = '0;
                  r_in     = '0;
                  state_in = ST_EDGE;
               end else begin
                  i_in = i_ff + NW'(1);
               end
            end else begin
               j_in = j_ff + NW'(1);
            end
         end
         ST_EDGE: begin
            // Four boundary cells per step k, held in i_ff.
            we_a = 1'b1;
            we_b = 1'b1;
            case (phase_ff)
               3'd0: begin
                  wr_row  = '0;
                  wr_col  = i_ff;
                  wr_data = sat_value(TEN_FX + d_ff);
               end
               3'd1: begin
                  wr_row  = i_ff;
                  wr_col  = '0;
                  wr_data = sat_value(TEN_FX + d_ff);
               end
               3'd2: begin
                  wr_row  = last;
                  wr_col  = i_ff;
                  wr_data = sat_value(TWENTY_FX + d_ff);
               end
               default: begin
                  wr_row  = i_ff;
                  wr_col  = last;
                  wr_data = sat_value(TWENTY_FX + d_ff);
               end
            endcase
            phase_in = phase_ff + 3'd1;
            if (phase_ff == 3'd3) begin
               phase_in = '0;
               if (rsum >= {1'b0, last}) begin
                  r_in = NW'(rsum - {1'b0, last});
                  d_in = d_ff + quo_ff + DIV_W'(1);
               end else begin
                  r_in = rsum[NW-1:0];
                  d_in = d_ff + quo_ff;
               end
               if (i_ff == last) begin
                  i_in   = NW'(1);
                  j_in   = NW'(1);
                  err_in = '0;
                  state_in = ST_SWEEP;
               end else begin
                  i_in = i_ff + NW'(1);
               end
            end
         end
         ST_SWEEP: begin
            // Five reads per cell: up, down, left, right, centre.
            case (phase_ff)
               3'd0: begin
                  rd_row = i_ff - NW'(1);
               end
               3'd1: begin
                  rd_row = i_ff + NW'(1);
               end
               3'd2: begin
                  rd_col = j_ff - NW'(1);
               end
               3'd3: begin
                  rd_col = j_ff + NW'(1);
               end
               default: begin
               end
            endcase
            if (phase_ff == 3'd1) begin
               sum_in = SUM_W'(src_data);
            end else if (phase_ff != 3'd0 && phase_ff != PH_LAST) begin
               sum_in = sum_ff + SUM_W'(src_data);
            end
            phase_in = phase_ff + 3'd1;
            if (phase_ff == PH_LAST) begin
               phase_in = '0;
               wr_data  = new_val;
               we_a     = sel_ff;
               we_b     = !sel_ff;
               err_in   = err_upd;
               if (j_ff == last - NW'(1)) begin
                  j_in = NW'(1);
                  if (i_ff == last - NW'(1)) begin
                     // End of a sweep: swap buffers and test the stop rule.
                     i_in    = NW'(1);
                     sel_in  = !sel_ff;
                     iter_in = iter_next;
                     err_in  = '0;
                     if (!((iter_next < limit) && (err_upd > tolerance_ff))) begin
                        sweep_count_in = iter_next;
                        sweep_error_in = err_upd;
                        pend_cell_in   = '0;
                        pend_status_in = 1'b0;
                        state_in       = ST_FINISH;
                     end
                  end else begin
                     i_in = i_ff + NW'(1);
                  end
               end else begin
                  j_in = j_ff + NW'(1);
               end
            end
         end
         ST_RADDR: begin
            state_in = ST_RDATA;
         end
         ST_RDATA: begin
            pend_cell_in   = src_data;
            pend_status_in = 1'b0;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_in.cell_value      = pend_cell_ff;
               rsp_in.iterations_used = sweep_count_ff;
               rsp_in.final_error     = sweep_error_ff;
               rsp_in.status          = pend_status_ff;
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         sel_ff         <= 1'b0;
         sweep_count_ff <= '0;
         sweep_error_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         grid_size_ff   <= SIZE_W'(8);
         tolerance_ff   <= VALUE_W'(6);
         max_iter_ff    <= ITER_W'(1000);
      end else begin
         state_ff       <= state_in;
         sel_ff         <= sel_in;
         sweep_count_ff <= sweep_count_in;
         sweep_error_ff <= sweep_error_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_GRID_SIZE: grid_size_ff <= csr_write_data[SIZE_W-1:0];
               CSR_TOLERANCE: tolerance_ff <= csr_write_data[VALUE_W-1:0];
               CSR_MAX_ITER:  max_iter_ff  <= csr_write_data[ITER_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rsp_ff         <= rsp_in;
      pend_cell_ff   <= pend_cell_in;
      pend_status_ff <= pend_status_in;
      i_ff           <= i_in;
      j_ff           <= j_in;
      phase_ff       <= phase_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      cnt_ff         <= cnt_in;
      d_ff           <= d_in;
      r_ff           <= r_in;
      sum_ff         <= sum_in;
      err_ff         <= err_in;
      iter_ff        <= iter_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The two grid buffers.
   jlgs_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(DEPTH)
   ) u_grid_a (
      .clock        (clock),
      .write_enable (we_a),
      .write_address(wr_addr),
      .write_data   (wr_data),
      .read_address (rd_addr),
      .read_data    (rd_a)
   );

   jlgs_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(DEPTH)
   ) u_grid_b (
      .clock        (clock),
      .write_enable (we_b),
      .write_address(wr_addr),
      .write_data   (wr_data),
      .read_address (rd_addr),
      .read_data    (rd_b)
   );

endmodule
`default_nettype wire

// File: rtl/core/jlgs_checker.sv
`default_nettype none
module jlgs_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire jlgs_pkg::rsp_type rsp_payload
);
   import jlgs_pkg::*;

   // A held response keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // A bad index never reports a cell value.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status |-> rsp_payload.cell_value == '0)
      else $error("bad-index response carries a cell value");

   // Only one request is in work at a time.
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // No response straight after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response present after reset");

endmodule

bind jacobi_laplace_grid_solver_core jlgs_checker u_jlgs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_payload(rsp_payload)
);
`default_nettype wire

// File: verif/jacobi_laplace_grid_solver_core_tb.sv
`default_nettype none
module jacobi_laplace_grid_solver_core_tb;
   import jlgs_pkg::*;

   localparam int CELL_COUNT   = 4096;
   localparam int ROW_STRIDE   = 64;
   localparam int WATCHDOG_MAX = 1500000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_payload;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   jacobi_laplace_grid_solver_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the solver state and its registers.
   logic [VALUE_W-1:0] shadow_grid [2][CELL_COUNT];
   bit                 shadow_sel;
   logic [ITER_W-1:0]  shadow_sweeps;
   logic [VALUE_W-1:0] shadow_error;
   logic [SIZE_W-1:0]  shadow_size;
   logic [VALUE_W-1:0] shadow_tolerance;
   logic [ITER_W-1:0]  shadow_max_iter;
   int                 solved_size;

   rsp_type pending_rsp_q[$];
   int      mismatch_count;
   bit      idling_on;
   int      rsp_hold_cycles;
   int      rsp_gap;
   int      req_gap_odds;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Side of the grid actually used, after clamping the register.
   function automatic int size_in_use();
      if (shadow_size < 3) return 3;
      if (shadow_size > ROW_STRIDE) return ROW_STRIDE;
      return int'(shadow_size);
   endfunction

   // Build both buffers and run Jacobi sweeps until the limit or convergence.
   task automatic run_jacobi_solve();
      int                 n;
      int                 c;
      logic [ITER_W-1:0]  limit;
      logic [ITER_W-1:0]  iter;
      logic [VALUE_W-1:0] err;
      logic [VALUE_W-1:0] v;
      logic [VALUE_W-1:0] old;
      logic [63:0]        d;
      logic [25:0]        sum;
      bit                 src;
      n = size_in_use();
      limit = (shadow_max_iter == 0) ? 1 : shadow_max_iter;
      for (int b = 0; b < 2; b++) begin
         for (int k = 0; k < CELL_COUNT; k++) shadow_grid[b][k] = '0;
         for (int k = 0; k < n; k++) begin
            d = ((64'd10 << FRACTION_BITS) * k) / (n - 1);
            shadow_grid[b][k] = VALUE_W'((64'd10 << FRACTION_BITS) + d);
            shadow_grid[b][k*ROW_STRIDE] = VALUE_W'((64'd10 << FRACTION_BITS) + d);
            shadow_grid[b][(n-1)*ROW_STRIDE+k] = VALUE_W'((64'd20 << FRACTION_BITS) + d);
            shadow_grid[b][k*ROW_STRIDE+n-1] = VALUE_W'((64'd20 << FRACTION_BITS) + d);
         end
      end
      iter = '0;
      do begin
         src = shadow_sel;
         err = '0;
         iter++;
         for (int i = 1; i + 1 < n; i++) begin
            for (int j = 1; j + 1 < n; j++) begin
               c = i * ROW_STRIDE + j;
               sum = 26'(shadow_grid[src][c-ROW_STRIDE]) + 26'(shadow_grid[src][c+ROW_STRIDE])
                   + 26'(shadow_grid[src][c-1]) + 26'(shadow_grid[src][c+1]);
               v = sum[25:2];
               old = shadow_grid[src][c];
               shadow_grid[!src][c] = v;
               if (v > old && v - old > err) err = v - old;
            end
         end
         shadow_sel = !shadow_sel;
      end while (iter < limit && err > shadow_tolerance);
      shadow_sweeps = iter;
      shadow_error = err;
      // A solve clears the whole of both buffers, so every cell now has a value.
      solved_size = ROW_STRIDE;
   endtask

   // Expected response for one accepted request.
   task automatic predict_response(input req_type r, output rsp_type e);
      int n;
      e = '0;
      if (r.mode == MODE_SOLVE) begin
         run_jacobi_solve();
      end else begin
         n = size_in_use();
         if (r.row >= n || r.column >= n) e.status = 1'b1;
         else e.cell_value = shadow_grid[shadow_sel][r.row*ROW_STRIDE+r.column];
      end
      e.iterations_used = shadow_sweeps;
      e.final_error = shadow_error;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   // Send one request, with an optional random gap first; valid stays high afterwards.
   task automatic send_request(input req_type r);
      rsp_type e;
      if (idling_on && $urandom_range(0, req_gap_odds) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload = r;
      do @(posedge clock); while (!req_ready);
      predict_response(r, e);
      pending_rsp_q.push_back(e);
      @(negedge clock);
   endtask

   task automatic send_solve();
      req_type r;
      r = '0;
      r.mode = MODE_SOLVE;
      r.row = 6'($urandom);
      r.column = 6'($urandom);
      send_request(r);
   endtask

   task automatic send_read(input int row, input int column);
      req_type r;
      r.mode = MODE_READ;
      r.row = 6'(row);
      r.column = 6'(column);
      send_request(r);
   endtask

   // A random read that never touches a cell left unwritten by the last solve.
   task automatic send_random_read();
      int row;
      int column;
      int n;
      n = size_in_use();
      do begin
         if ($urandom_range(0, 3) == 0) begin
            row = $urandom_range(0, 63);
            column = $urandom_range(0, 63);
         end else begin
            row = $urandom_range(0, n);
            column = $urandom_range(0, n);
         end
      end while (row < n && column < n && (row >= solved_size || column >= solved_size));
      send_read(row, column);
   endtask

   // Stop offering and wait until every response has come back.
   task automatic drain_responses();
      req_valid = 1'b0;
      while (pending_rsp_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (idx)
         CSR_GRID_SIZE: shadow_size = data[SIZE_W-1:0];
         CSR_TOLERANCE: shadow_tolerance = data[VALUE_W-1:0];
         CSR_MAX_ITER:  shadow_max_iter = data[ITER_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input int size, input int tol, input int max_iter);
      drain_responses();
      write_register(CSR_GRID_SIZE, CSR_DATA_W'(size));
      write_register(CSR_TOLERANCE, CSR_DATA_W'(tol));
      write_register(CSR_MAX_ITER, CSR_DATA_W'(max_iter));
   endtask

   // Defaults after reset: corners, edges, interior, reads just past and far off the grid.
   task automatic test_default_solve();
      send_solve();
      send_read(0, 0);
      send_read(0, 7);
      send_read(7, 0);
      send_read(7, 7);
      send_read(3, 4);
      send_read(1, 1);
      send_read(8, 0);
      send_read(0, 8);
      send_read(63, 63);
      send_read(42, 21);
      send_solve();
      send_read(6, 6);
   endtask

   // Register extremes, including sizes clamped at both ends and a zero sweep limit.
   task automatic test_register_extremes();
      configure(0, 0, 20'hFFFFF);
      send_solve();
      send_read(1, 1);
      send_read(2, 2);
      send_read(3, 0);
      configure(2, 24'hFFFFFF, 0);
      send_solve();
      send_read(1, 1);
      configure(127, 24'hFFFFFF, 0);
      send_solve();
      send_read(63, 63);
      send_read(0, 63);
      send_read(32, 31);
      configure(64, 0, 2);
      send_solve();
      send_read(1, 1);
      send_read(62, 62);
      configure(3, 0, 1);
      send_solve();
      send_read(1, 1);
   endtask

   // The receiver holds off for a long stretch while reads keep coming.
   task automatic test_response_backpressure();
      configure(5, 100, 10);
      send_solve();
      drain_responses();
      rsp_hold_cycles = 400;
      for (int k = 0; k < 8; k++) send_random_read();
      drain_responses();
   endtask

   // Random phases: each sets the registers, solves, then mixes reads and solves.
   task automatic test_random_traffic(input int requests);
      int sent;
      sent = 0;
      while (sent < requests) begin
         configure($urandom_range(3, 10), $urandom_range(0, 4) == 0 ? $urandom :
                   $urandom_range(0, 2000), $urandom_range(0, 25));
         send_solve();
         sent++;
         repeat ($urandom_range(4, 14)) begin
            if ($urandom_range(0, 9) == 0) send_solve();
            else send_random_read();
            sent++;
         end
      end
   endtask

   // Receiver side: long hold when asked, otherwise random stall bursts.
   initial begin
      rsp_ready = 1'b0;
      rsp_gap = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready = 1'b0;
            rsp_hold_cycles--;
         end else if (rsp_gap > 0) begin
            rsp_ready = 1'b0;
            rsp_gap--;
         end else begin
            rsp_ready = 1'b1;
            if (idling_on && $urandom_range(0, 7) == 0) rsp_gap = $urandom_range(1, 10);
         end
      end
   end

   // Compare each accepted response with the oldest expectation.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp_q.size() == 0) begin
            report_mismatch("unexpected response", 32'(rsp_payload.status), 32'h0);
         end else begin
            e = pending_rsp_q.pop_front();
            if (rsp_payload.cell_value !== e.cell_value)
               report_mismatch("cell_value", 32'(rsp_payload.cell_value), 32'(e.cell_value));
            if (rsp_payload.iterations_used !== e.iterations_used)
               report_mismatch("iterations_used", 32'(rsp_payload.iterations_used),
                               32'(e.iterations_used));
            if (rsp_payload.final_error !== e.final_error)
               report_mismatch("final_error", 32'(rsp_payload.final_error),
                               32'(e.final_error));
            if (rsp_payload.status !== e.status)
               report_mismatch("status", 32'(rsp_payload.status), 32'(e.status));
         end
      end
   end

   // Watchdog on cycles in which no request and no response moves.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
         if (quiet >= WATCHDOG_MAX) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      mismatch_count = 0;
      idling_on = 1'b1;
      rsp_hold_cycles = 0;
      req_gap_odds = 3;
      shadow_sel = 1'b0;
      shadow_sweeps = '0;
      shadow_error = '0;
      shadow_size = 7'd8;
      shadow_tolerance = 24'd6;
      shadow_max_iter = 20'd1000;
      solved_size = 0;
      repeat (2) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_default_solve();
      test_register_extremes();
      test_response_backpressure();
      test_random_traffic(70);
      drain_responses();
      idling_on = 1'b0;
      test_random_traffic(30);
      drain_responses();
      repeat (20) @(negedge clock);

      if (mismatch_count == 0 && pending_rsp_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
